>>> src/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Types and constants shared by the program stream PES demux files.
// ----------------------------------------------------------------------------
package psd_pkg;

    localparam int POS_W = 17;   // byte position inside a unit, up to 6 + 65535
    localparam int HDR_W = 9;    // payload start offset, up to 9 + 255 + 15

    localparam logic [7:0] CODE_PROGRAM_END = 8'hB9;
    localparam logic [7:0] CODE_PACK        = 8'hBA;
    localparam logic [7:0] CODE_PES_MIN     = 8'hBB;
    localparam logic [7:0] CODE_PRIVATE_1   = 8'hBD;
    localparam logic [7:0] CODE_VIDEO_LO    = 8'hE0;
    localparam logic [7:0] CODE_VIDEO_HI    = 8'hEF;
    localparam logic [7:0] MARKER_MASK      = 8'hC0;
    localparam logic [7:0] MARKER_BITS      = 8'h80;

    localparam logic [POS_W-1:0] START_CODE_LEN = 17'd4;
    localparam logic [POS_W-1:0] PACK_HDR_LEN   = 17'd14;
    localparam logic [POS_W-1:0] PES_FIXED_LEN  = 17'd6;
    localparam logic [POS_W-1:0] PES_HDR_POS    = 17'd8;
    localparam logic [POS_W-1:0] PES_HDR_LEN    = 17'd9;
    localparam logic [POS_W-1:0] PACK_STUFF_POS = 17'd13;
    localparam logic [POS_W-1:0] PES_LEN_HI_POS = 17'd4;
    localparam logic [POS_W-1:0] PES_LEN_LO_POS = 17'd5;
    localparam logic [POS_W-1:0] PES_FLAGS_POS  = 17'd6;
    localparam logic [15:0]      PES_MIN_LEN    = 16'd3;

    localparam logic [3:0] AUDIO_PREFIX_RESET = 4'd4;
    localparam logic       VIDEO_ENABLE_RESET = 1'b1;

    localparam logic CFG_AUDIO_PREFIX = 1'b0;
    localparam logic CFG_VIDEO_ENABLE = 1'b1;

    typedef enum logic [2:0] {
        PH_SCAN = 3'd0,
        PH_CODE = 3'd1,
        PH_PACK = 3'd2,
        PH_PES  = 3'd3,
        PH_END  = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_in_buffer;
    } in_item_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic       stream_kind;
        logic       last_of_packet;
        logic       truncated;
    } out_item_t;

    typedef struct packed {
        logic       valid;
        logic       index;
        logic [3:0] data;
    } cfg_write_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } psd_result_t;

endpackage

>>> src/psd_parser.sv
// ----------------------------------------------------------------------------
// psd_parser
// Per-byte start code scanner and PES parser; at most one result per accepted item.
// ----------------------------------------------------------------------------
module psd_parser
    import psd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  in_item_t    in_item,
    input  cfg_write_t  cfg,
    output psd_result_t result
);

    logic [3:0]       audio_prefix_reg;
    logic             video_enable_reg;

    phase_t           phase_reg, phase_next;
    logic [1:0]       zero_run_reg, zero_run_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] total_reg, total_next;
    logic [HDR_W-1:0] hdr_end_reg, hdr_end_next;
    logic             kind_reg, kind_next;
    logic             selected_reg, selected_next;
    logic             started_reg, started_next;

    logic [7:0]       b;
    logic [POS_W-1:0] pos_inc;
    logic [15:0]      pes_len;
    logic             emit;
    logic             marker;

    assign b       = in_item.data_byte;
    assign pos_inc = pos_reg + 17'd1;
    assign pes_len = {total_reg[15:8], b};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            audio_prefix_reg <= AUDIO_PREFIX_RESET;
            video_enable_reg <= VIDEO_ENABLE_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_AUDIO_PREFIX: audio_prefix_reg <= cfg.data;
                CFG_VIDEO_ENABLE: video_enable_reg <= cfg.data[0];
                default:          audio_prefix_reg <= audio_prefix_reg;
            endcase
        end
    end

    // next state
    always_comb
    begin
        phase_next    = phase_reg;
        zero_run_next = zero_run_reg;
        pos_next      = pos_reg;
        total_next    = total_reg;
        hdr_end_next  = hdr_end_reg;
        kind_next     = kind_reg;
        selected_next = selected_reg;
        started_next  = started_reg;
        case (phase_reg)
            PH_CODE:
            begin
                zero_run_next = 2'd0;
                if (b == CODE_PACK)
                begin
                    phase_next = PH_PACK;
                    pos_next   = START_CODE_LEN;
                    total_next = PACK_HDR_LEN;
                end
                else if (b == CODE_PROGRAM_END)
                begin
                    phase_next = PH_END;
                end
                else if (b < CODE_PES_MIN)
                begin
                    phase_next = PH_SCAN;
                end
                else
                begin
                    phase_next    = PH_PES;
                    pos_next      = START_CODE_LEN;
                    total_next    = '0;
                    hdr_end_next  = PES_HDR_LEN[HDR_W-1:0];
                    kind_next     = (b == CODE_PRIVATE_1);
                    selected_next = ((b inside {[CODE_VIDEO_LO:CODE_VIDEO_HI]})
                                     && video_enable_reg) || (b == CODE_PRIVATE_1);
                    started_next  = 1'b0;
                end
            end
            PH_PACK:
            begin
                if (pos_reg == PACK_STUFF_POS)
                    total_next = PACK_HDR_LEN + {14'd0, b[2:0]};
                pos_next = pos_inc;
                if (pos_inc >= total_next)
                    phase_next = PH_SCAN;
            end
            PH_PES:
            begin
                if (pos_reg == PES_LEN_HI_POS)
                begin
                    total_next = {1'b0, b, 8'd0};
                end
                else if (pos_reg == PES_LEN_LO_POS)
                begin
                    total_next = PES_FIXED_LEN + {1'b0, pes_len};
                    if (pes_len < PES_MIN_LEN)
                        selected_next = 1'b0;
                end
                else
                begin
                    if (pos_reg == PES_FLAGS_POS && (b & MARKER_MASK) != MARKER_BITS)
                        selected_next = 1'b0;
                    if (pos_reg == PES_HDR_POS)
                        hdr_end_next = PES_HDR_LEN[HDR_W-1:0] + {1'b0, b}
                                       + (kind_reg ? {5'd0, audio_prefix_reg} : 9'd0);
                end
                if (emit)
                    started_next = 1'b1;
                pos_next = pos_inc;
                if (pos_inc >= PES_FIXED_LEN && pos_inc >= total_next)
                    phase_next = PH_SCAN;
            end
            PH_END:
            begin
                phase_next = PH_END;
            end
            default:
            begin
                phase_next = PH_SCAN;
                if (b == 8'd0)
                begin
                    if (zero_run_reg < 2'd2)
                        zero_run_next = zero_run_reg + 2'd1;
                end
                else if (b == 8'd1 && zero_run_reg >= 2'd2)
                begin
                    phase_next    = PH_CODE;
                    zero_run_next = 2'd0;
                end
                else
                begin
                    zero_run_next = 2'd0;
                end
            end
        endcase
    end

    // outputs; selection and header end cannot change on a payload byte
    always_comb
    begin
        emit = (phase_reg == PH_PES) && (pos_reg >= PES_HDR_LEN)
               && (pos_reg >= {8'd0, hdr_end_reg}) && selected_reg;
        marker = in_item.last_in_buffer && (phase_next == PH_PES) && selected_next
                 && !emit && started_reg;
        result.valid               = accept && (emit || marker);
        result.item.payload_byte   = emit ? b : 8'd0;
        result.item.byte_valid     = emit;
        result.item.stream_kind    = kind_next;
        result.item.last_of_packet = emit && (pos_inc == total_reg);
        result.item.truncated      = in_item.last_in_buffer && (phase_next == PH_PES)
                                     && selected_next && (emit || started_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SCAN;
            zero_run_reg <= '0;
            pos_reg      <= '0;
            total_reg    <= '0;
            hdr_end_reg  <= '0;
            kind_reg     <= 1'b0;
            selected_reg <= 1'b0;
            started_reg  <= 1'b0;
        end
        else if (accept)
        begin
            if (in_item.last_in_buffer)
            begin
                phase_reg    <= PH_SCAN;
                zero_run_reg <= '0;
                pos_reg      <= '0;
                total_reg    <= '0;
                hdr_end_reg  <= '0;
                kind_reg     <= 1'b0;
                selected_reg <= 1'b0;
                started_reg  <= 1'b0;
            end
            else
            begin
                phase_reg    <= phase_next;
                zero_run_reg <= zero_run_next;
                pos_reg      <= pos_next;
                total_reg    <= total_next;
                hdr_end_reg  <= hdr_end_next;
                kind_reg     <= kind_next;
                selected_reg <= selected_next;
                started_reg  <= started_next;
            end
        end
    end

`ifndef ASSERT_OFF
    a_result_has_data_or_mark: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.item.byte_valid || result.item.truncated))
        else $error("result with neither data nor truncation mark");

    a_last_not_truncated: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.item.last_of_packet)
            |-> (result.item.byte_valid && !result.item.truncated))
        else $error("packet end flagged as truncated");

    a_buffer_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_item.last_in_buffer) |=> (phase_reg == PH_SCAN && !started_reg))
        else $error("parser not cleared after buffer end");

    a_emit_only_when_selected: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.item.byte_valid) |-> selected_reg)
        else $error("payload from an unselected packet");
`endif

endmodule

>>> src/program_stream_pes_demux.sv
// ----------------------------------------------------------------------------
// program_stream_pes_demux
// Program stream demux: emits video and private stream 1 PES payload bytes.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one program stream byte per item, with last_in_buffer set on
//            the final byte of each buffer. Accepted when in_valid is high
//            and in_stall is low.
//   out_*  : payload items (byte, kind, end of packet, truncation flag).
//            Taken when out_valid is high and out_stall is low.
//   cfg_*  : register writes (index 0 audio prefix bytes, 1 video enable);
//            cfg_ready is always high. Write only while the block is idle.
// Throughput is one item per cycle while in_stall is low; a result is
// written to the output register, or to the skid register if out_* is held.
// The parser state update for one byte sits between the input handshake and
// the output register. A two-entry output stage (output register plus skid
// register) lets input go on while the receiver stalls, until one result
// fills the skid register; in_stall rises only when both entries are full.
// Reset clears the parser to start code scanning, empties the output stage
// and sets the registers to audio prefix 4 and video enabled.
// ----------------------------------------------------------------------------
module program_stream_pes_demux
    import psd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [3:0] cfg_data
);

    logic        accept;
    logic        out_take;
    cfg_write_t  cfg;
    psd_result_t result;

    logic        out_valid_reg;
    out_item_t   out_item_reg;
    logic        skid_valid_reg;
    out_item_t   skid_item_reg;

    assign cfg_ready  = 1'b1;
    assign cfg.valid  = cfg_valid;
    assign cfg.index  = cfg_index;
    assign cfg.data   = cfg_data;

    assign in_stall   = skid_valid_reg;
    assign accept     = in_valid && !skid_valid_reg;
    assign out_take   = out_valid_reg && !out_stall;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_item_reg;

    psd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_item (in_data),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (out_take)
                    skid_valid_reg <= 1'b0;
            end
            else if (result.valid)
            begin
                if (out_valid_reg && !out_take)
                    skid_valid_reg <= 1'b1;
                else
                    out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload side, no reset needed
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
                out_item_reg <= skid_item_reg;
        end
        else if (result.valid)
        begin
            if (out_valid_reg && !out_take)
                skid_item_reg <= result.item;
            else
                out_item_reg <= result.item;
        end
    end

`ifndef ASSERT_OFF
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_stalled_out_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("stalled item dropped");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_take) |=> (!skid_valid_reg && out_valid_reg))
        else $error("skid entry not moved to output register");
`endif

endmodule
